### hdl/ehc_pkg.sv
// Shared types, constants and helpers for the expiring hash cache lookup core.
`default_nettype none
package ehc_pkg;

  // Field widths of the request and result channels
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned SLOT_W = 10;

  // Default geometry; the cell index never needs more than IDX_MAX_W bits
  localparam int unsigned CELLS_DEF     = 1024;
  localparam int unsigned PROBE_LEN_DEF = 10;
  localparam int unsigned IDX_MAX_W     = 20;

  // Depth of the front-to-back request queue (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  // Hash finalizer multipliers
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  // Result codes
  typedef enum logic [1:0] {
    STAT_HIT     = 2'd0,
    STAT_EXPIRED = 2'd1,
    STAT_MISS    = 2'd2,
    STAT_WRITE   = 2'd3
  } status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE,
    BK_DONE
  } back_state_t;

  // Request as it arrives on the ports
  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [SLOT_W-1:0] write_slot;
    logic [TIME_W-1:0] write_expiry;
    logic              write_is_default;
  } item_t;

  // Classified request handed from front to back: idx is the probe start
  // for a lookup and the target cell for a write
  typedef struct packed {
    logic                 mode;
    logic [KEY_W-1:0]     key;
    logic [TIME_W-1:0]    now;
    logic [IDX_MAX_W-1:0] idx;
    logic [TIME_W-1:0]    write_expiry;
    logic                 write_is_default;
  } req_t;

  // One cell of the table
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] expiry;
    logic              dflt;
  } cell_t;

  // xor-shift step of the finalizer
  function automatic logic [KEY_W-1:0] fold33(input logic [KEY_W-1:0] x);
    return x ^ (x >> 33);
  endfunction

endpackage
`default_nettype wire

### hdl/ehc_front.sv
// Front end: accepts requests and computes the probe start index through a hash pipeline.
`default_nettype none
module ehc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           hold,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ehc_pkg::item_t in_item,
  output logic                q_push,
  output ehc_pkg::req_t       q_data,
  input  wire logic           q_full
);
  import ehc_pkg::*;

  localparam int unsigned STAGES = 5;

  logic              adv;
  logic [STAGES-1:0] v;
  item_t             it [STAGES];

  // hash intermediates, one group per stage
  logic [KEY_W-1:0]     x1;
  logic [KEY_W-1:0]     a_lo;
  logic [31:0]          a_h1;
  logic [31:0]          a_h2;
  logic [KEY_W-1:0]     y2;
  logic [KEY_W-1:0]     b_lo;
  logic [31:0]          b_h1;
  logic [31:0]          b_h2;
  logic [IDX_MAX_W-1:0] start4;
  logic [KEY_W-1:0]     x3;
  logic [KEY_W-1:0]     h3;

  // whole pipe moves unless the last stage is blocked by a full queue
  assign adv      = !(v[STAGES-1] && q_full);
  assign in_ready = adv && !hold;

  // product of the second multiplication and its final fold; low 64 bits from 32x32 parts
  assign x3 = b_lo + {b_h1 + b_h2, 32'b0};
  assign h3 = fold33(x3);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[STAGES-2:0], in_valid && in_ready};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      it[0]  <= in_item;
      x1     <= fold33(in_item.key);
      it[1]  <= it[0];
      a_lo   <= 64'(x1[31:0]) * 64'(MIX_C1[31:0]);
      a_h1   <= x1[31:0] * MIX_C1[63:32];
      a_h2   <= x1[63:32] * MIX_C1[31:0];
      it[2]  <= it[1];
      y2     <= fold33(a_lo + {a_h1 + a_h2, 32'b0});
      it[3]  <= it[2];
      b_lo   <= 64'(y2[31:0]) * 64'(MIX_C2[31:0]);
      b_h1   <= y2[31:0] * MIX_C2[63:32];
      b_h2   <= y2[63:32] * MIX_C2[31:0];
      it[4]  <= it[3];
      start4 <= h3[IDX_MAX_W-1:0];
    end
  end

  // classified request into the queue
  always_comb begin
    q_push                  = v[STAGES-1];
    q_data.mode             = it[4].mode;
    q_data.key              = it[4].key;
    q_data.now              = it[4].now;
    q_data.idx              = it[4].mode ? IDX_MAX_W'(it[4].write_slot) : start4;
    q_data.write_expiry     = it[4].write_expiry;
    q_data.write_is_default = it[4].write_is_default;
  end

endmodule
`default_nettype wire

### hdl/ehc_queue.sv
// Short request queue between the front and back ends.
`default_nettype none
module ehc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ehc_pkg::req_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output ehc_pkg::req_t      pop_data
);
  import ehc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/ehc_back.sv
// Back end: cell table, clearing pass, write and probe sequencer, result register.
`default_nettype none
module ehc_back #(
  parameter int unsigned CELLS     = ehc_pkg::CELLS_DEF,
  parameter int unsigned PROBE_LEN = ehc_pkg::PROBE_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire ehc_pkg::req_t              q_data,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output logic [1:0]                      status,
  output logic [ehc_pkg::SLOT_W-1:0]      slot,
  output logic                            present
);
  import ehc_pkg::*;

  localparam int unsigned IDX_W = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(PROBE_LEN + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CELLS - 1);
  localparam logic [CNT_W-1:0] PROBE_CNT = CNT_W'(PROBE_LEN);

  // cell table, single port with registered read
  cell_t             mem [CELLS];
  cell_t             rd_word;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_addr;
  cell_t             mem_wdata;

  back_state_t       state, state_next;
  logic [IDX_W-1:0]  clr_cnt, clr_cnt_next;
  logic [KEY_W-1:0]  cur_key, cur_key_next;
  logic [TIME_W-1:0] cur_now, cur_now_next;
  logic [IDX_W-1:0]  cur_idx, cur_idx_next;
  logic [CNT_W-1:0]  iss_cnt, iss_cnt_next;
  logic [CNT_W-1:0]  ev_cnt, ev_cnt_next;
  logic              rd_valid, rd_valid_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic [KEY_W-1:0]  best_time, best_time_next;
  logic [IDX_W-1:0]  best_idx, best_idx_next;
  status_t           res_status, res_status_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic              res_present, res_present_next;
  logic              rsp_valid_next;
  status_t           out_status, out_status_next;
  logic [SLOT_W-1:0] slot_next;
  logic              present_next;

  assign clearing = (state == BK_CLEAR);
  assign status   = out_status;

  // table access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word <= mem[mem_addr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      iss_cnt   <= '0;
      ev_cnt    <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      iss_cnt   <= iss_cnt_next;
      ev_cnt    <= ev_cnt_next;
      rd_valid  <= rd_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    cur_key     <= cur_key_next;
    cur_now     <= cur_now_next;
    cur_idx     <= cur_idx_next;
    rd_idx      <= rd_idx_next;
    best_time   <= best_time_next;
    best_idx    <= best_idx_next;
    res_status  <= res_status_next;
    res_slot    <= res_slot_next;
    res_present <= res_present_next;
    out_status  <= out_status_next;
    slot        <= slot_next;
    present     <= present_next;
  end

  // sequencer
  always_comb begin
    state_next       = state;
    clr_cnt_next     = clr_cnt;
    cur_key_next     = cur_key;
    cur_now_next     = cur_now;
    cur_idx_next     = cur_idx;
    iss_cnt_next     = iss_cnt;
    ev_cnt_next      = ev_cnt;
    rd_valid_next    = 1'b0;
    rd_idx_next      = rd_idx;
    best_time_next   = best_time;
    best_idx_next    = best_idx;
    res_status_next  = res_status;
    res_slot_next    = res_slot;
    res_present_next = res_present;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    out_status_next  = out_status;
    slot_next        = slot;
    present_next     = present;
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_addr         = '0;
    mem_wdata        = '0;

    unique case (state)
      // zero one cell per cycle after reset
      BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_IDX) begin
          state_next = BK_IDLE;
        end
      end

      // take the next request: writes finish here, lookups start probing
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.mode) begin
            mem_we           = 1'b1;
            mem_addr         = IDX_W'(q_data.idx);
            mem_wdata.key    = q_data.key;
            mem_wdata.expiry = q_data.write_expiry;
            mem_wdata.dflt   = q_data.write_is_default;
            res_status_next  = STAT_WRITE;
            res_slot_next    = SLOT_W'(IDX_W'(q_data.idx));
            res_present_next = 1'b0;
            state_next       = BK_DONE;
          end else begin
            cur_key_next   = q_data.key;
            cur_now_next   = q_data.now;
            cur_idx_next   = IDX_W'(q_data.idx);
            iss_cnt_next   = '0;
            ev_cnt_next    = '0;
            best_time_next = '1;
            best_idx_next  = IDX_W'(q_data.idx);
            state_next     = BK_PROBE;
          end
        end
      end

      // issue one read per cycle, judge the cell read the cycle before
      BK_PROBE: begin
        mem_re        = (iss_cnt < PROBE_CNT);
        mem_addr      = cur_idx + IDX_W'(iss_cnt);
        rd_valid_next = mem_re;
        rd_idx_next   = mem_addr;
        if (mem_re) begin
          iss_cnt_next = iss_cnt + 1'b1;
        end
        if (rd_valid) begin
          ev_cnt_next = ev_cnt + 1'b1;
          if (rd_word.key == cur_key) begin
            res_slot_next = SLOT_W'(rd_idx);
            if (rd_word.expiry < cur_now) begin
              res_status_next  = STAT_EXPIRED;
              res_present_next = 1'b0;
            end else begin
              res_status_next  = STAT_HIT;
              res_present_next = !rd_word.dflt;
            end
            rd_valid_next = 1'b0;
            state_next    = BK_DONE;
          end else begin
            // earliest expiry, frozen once the candidate's expiry is no later than now
            if (best_time > {1'b0, cur_now} && best_time > {1'b0, rd_word.expiry}) begin
              best_time_next = {1'b0, rd_word.expiry};
              best_idx_next  = rd_idx;
            end
            if (ev_cnt_next == PROBE_CNT) begin
              res_status_next  = STAT_MISS;
              res_slot_next    = SLOT_W'(best_idx_next);
              res_present_next = 1'b0;
              rd_valid_next    = 1'b0;
              state_next       = BK_DONE;
            end
          end
        end
      end

      // hand the result to the output register once it is free
      BK_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next  = 1'b1;
          out_status_next = res_status;
          slot_next       = res_slot;
          present_next    = res_present;
          state_next      = BK_IDLE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/expiring_hash_cache_lookup_core.sv
// Lookup path from request accept to rsp_valid: 5 hash stages, queue, probes, result register;
// the back end takes one request at a time, with one probe read per cycle on the single-ported
// cell table. A write goes into the table as it leaves the queue, then to the result register.
// After reset the table is zeroed by a clearing pass over every cell, during which
// req_ready stays low.
// Top level of the expiring hash cache lookup core.
`default_nettype none
module expiring_hash_cache_lookup_core #(
  parameter int unsigned CELLS     = ehc_pkg::CELLS_DEF,
  parameter int unsigned PROBE_LEN = ehc_pkg::PROBE_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic                         mode,
  input  wire logic [ehc_pkg::KEY_W-1:0]    key,
  input  wire logic [ehc_pkg::TIME_W-1:0]   now,
  input  wire logic [ehc_pkg::SLOT_W-1:0]   write_slot,
  input  wire logic [ehc_pkg::TIME_W-1:0]   write_expiry,
  input  wire logic                         write_is_default,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output logic [1:0]                        status,
  output logic [ehc_pkg::SLOT_W-1:0]        slot,
  output logic                              present
);
  import ehc_pkg::*;

  item_t in_item;
  req_t  fq_data;
  req_t  qb_data;
  logic  fq_push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  clearing;

  // gather the request fields
  always_comb begin
    in_item.mode             = mode;
    in_item.key              = key;
    in_item.now              = now;
    in_item.write_slot       = write_slot;
    in_item.write_expiry     = write_expiry;
    in_item.write_is_default = write_is_default;
  end

  ehc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .in_valid (req_valid),
    .in_ready (req_ready),
    .in_item  (in_item),
    .q_push   (fq_push),
    .q_data   (fq_data),
    .q_full   (q_full)
  );

  ehc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (qb_data)
  );

  ehc_back #(
    .CELLS     (CELLS),
    .PROBE_LEN (PROBE_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (qb_data),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .slot      (slot),
    .present   (present)
  );

endmodule
`default_nettype wire

### hdl/ehc_checker.sv
// Port-level assertions for the lookup core, bound to the top level.
`default_nettype none
module ehc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [1:0]                 status,
  input wire logic [ehc_pkg::SLOT_W-1:0] slot,
  input wire logic                       present
);
  import ehc_pkg::*;

  // no request is taken right after reset: the clearing pass runs first
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request ready while table is being cleared");

  // result register is empty right after reset
  a_no_rsp_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot)
      && $stable(present))
    else $error("stalled result changed");

  // present only ever accompanies a hit; its hold across a stall is checked by a_rsp_hold
  a_present_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && present |-> status == STAT_HIT)
    else $error("present set outside a hit");

endmodule

bind expiring_hash_cache_lookup_core ehc_checker u_ehc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .status    (status),
  .slot      (slot),
  .present   (present)
);
`default_nettype wire
